// ----- hdl/swbrm_pkg.sv -----
// Shared constants and types for the sliding-window byte-rate meter.
package swbrm_pkg;

    // ring geometry defaults
    localparam int BUCKETS         = 20;
    localparam int BUCKET_MS       = 250;
    localparam int RECENT_BUCKETS  = 4;

    // field widths
    localparam int OP_W    = 2;
    localparam int TIME_W  = 16;
    localparam int BYTE_W  = 32;

    // recent query goes stale above this many milliseconds
    localparam logic [TIME_W-1:0] RECENT_LIMIT_MS = 16'd5000;

    // average divides the window sum by 5: x / 5 == (x * 0xCCCCCCCD) >> 34
    localparam logic [BYTE_W-1:0] AVG_RECIP = 32'hCCCC_CCCD;
    localparam int                AVG_SHIFT = 34;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_AVG    = 2'd1,
        OP_RECENT = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV,
        S_STEP,
        S_ADD_RD,
        S_ADD_WR,
        S_SUM,
        S_SUM_END,
        S_MUL,
        S_QUOT,
        S_DONE
    } t_state;

endpackage

// ----- hdl/swbrm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module swbrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sliding_window_byte_rate_meter_top.sv -----
// Top level of the sliding-window byte-rate meter: sequencer, timer and ring control.
//
// A request is taken when start is high and busy is low; busy then stays high until the
// single result has been shown on o_rate_value for one cycle with o_valid high. The
// receiver cannot stall, so o_valid is a one-cycle strobe. One shared subtract-and-compare
// unit walks the ring, advancing it by at most BUCKETS buckets, and summing reads one bucket
// a cycle from the bucket RAM. Add and average first advance the ring; add then reads and
// writes the newest bucket, average sums all BUCKETS buckets (one 32x32 multiply for the
// divide by 5), recent sums RECENT_BUCKETS buckets, and a stale recent or unused opcode
// goes straight to the strobe. A new request is taken the cycle after the
// strobe. Bucket contents are cleared by per-bucket valid flags, so no clearing pass runs
// after reset.
module sliding_window_byte_rate_meter_top #(
    parameter int BUCKETS        = swbrm_pkg::BUCKETS,
    parameter int BUCKET_MS      = swbrm_pkg::BUCKET_MS,
    parameter int RECENT_BUCKETS = swbrm_pkg::RECENT_BUCKETS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [swbrm_pkg::OP_W-1:0]   i_opcode,
    input  logic [swbrm_pkg::TIME_W-1:0] i_elapsed_ms,
    input  logic [swbrm_pkg::BYTE_W-1:0] i_byte_count,
    output logic                        o_valid,
    output logic [swbrm_pkg::BYTE_W-1:0] o_rate_value
);

    localparam int AW     = $clog2(BUCKETS);
    localparam int KMAX   = (BUCKETS > RECENT_BUCKETS) ? BUCKETS : RECENT_BUCKETS;
    localparam int KW     = $clog2(KMAX + 1);
    localparam int TW     = swbrm_pkg::TIME_W;
    localparam int BW     = swbrm_pkg::BYTE_W;
    localparam int PW     = 2 * BW;

    swbrm_pkg::t_state r_state, n_state;
    swbrm_pkg::t_op    r_op,    n_op;

    logic [TW-1:0]      r_timer, n_timer;
    logic [AW-1:0]      r_cur,   n_cur;
    logic [AW-1:0]      r_addr,  n_addr;
    logic [KW-1:0]      r_k,     n_k;
    logic [BUCKETS-1:0] r_valid, n_valid;
    logic               r_vq,    n_vq;
    logic               r_pend,  n_pend;
    logic [BW-1:0]      r_bytes, n_bytes;
    logic [BW-1:0]      r_acc,   n_acc;
    logic [BW-1:0]      r_result, n_result;
    logic [PW-1:0]      r_prod,  n_prod;

    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [BW-1:0]      ram_wdata;
    logic [BW-1:0]      ram_rdata;

    logic [TW:0]        timer_sum;
    logic [TW-1:0]      timer_sat;
    logic [BW-1:0]      bucket_rd;
    logic               step_go;
    logic               sum_last;
    logic [AW-1:0]      cur_inc;
    logic [AW-1:0]      addr_inc;
    logic [AW-1:0]      addr_dec;

    swbrm_ram #(
        .WIDTH (BW),
        .DEPTH (BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cur),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // saturating timer update and shared step compare
    assign timer_sum = {1'b0, r_timer} + {1'b0, i_elapsed_ms};
    assign timer_sat = timer_sum[TW] ? {TW{1'b1}} : timer_sum[TW-1:0];
    assign step_go   = (r_k < KW'(BUCKETS)) && (r_timer >= TW'(BUCKET_MS));
    assign bucket_rd = r_vq ? ram_rdata : '0;
    assign cur_inc   = (r_cur == AW'(BUCKETS - 1)) ? '0 : r_cur + 1'b1;
    assign addr_inc  = (r_addr == AW'(BUCKETS - 1)) ? '0 : r_addr + 1'b1;
    assign addr_dec  = (r_addr == '0) ? AW'(BUCKETS - 1) : r_addr - 1'b1;
    assign sum_last  = (r_op == swbrm_pkg::OP_AVG) ? (r_k == KW'(BUCKETS - 1))
                                                   : (r_k == KW'(RECENT_BUCKETS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swbrm_pkg::S_IDLE: begin
                if (start) begin
                    case (swbrm_pkg::t_op'(i_opcode))
                        swbrm_pkg::OP_ADD,
                        swbrm_pkg::OP_AVG:    n_state = swbrm_pkg::S_ADV;
                        swbrm_pkg::OP_RECENT: n_state = (timer_sat > swbrm_pkg::RECENT_LIMIT_MS)
                                                        ? swbrm_pkg::S_DONE : swbrm_pkg::S_SUM;
                        default:              n_state = swbrm_pkg::S_DONE;
                    endcase
                end
            end
            swbrm_pkg::S_ADV: begin
                if (r_timer > TW'(BUCKET_MS)) begin
                    n_state = swbrm_pkg::S_STEP;
                end else if (r_op == swbrm_pkg::OP_ADD) begin
                    n_state = swbrm_pkg::S_ADD_RD;
                end else begin
                    n_state = swbrm_pkg::S_SUM;
                end
            end
            swbrm_pkg::S_STEP: begin
                if (!step_go) begin
                    n_state = (r_op == swbrm_pkg::OP_ADD) ? swbrm_pkg::S_ADD_RD
                                                          : swbrm_pkg::S_SUM;
                end
            end
            swbrm_pkg::S_ADD_RD:  n_state = swbrm_pkg::S_ADD_WR;
            swbrm_pkg::S_ADD_WR:  n_state = swbrm_pkg::S_DONE;
            swbrm_pkg::S_SUM: begin
                if (sum_last) begin
                    n_state = swbrm_pkg::S_SUM_END;
                end
            end
            swbrm_pkg::S_SUM_END: begin
                n_state = (r_op == swbrm_pkg::OP_AVG) ? swbrm_pkg::S_MUL : swbrm_pkg::S_DONE;
            end
            swbrm_pkg::S_MUL:     n_state = swbrm_pkg::S_QUOT;
            swbrm_pkg::S_QUOT:    n_state = swbrm_pkg::S_DONE;
            swbrm_pkg::S_DONE:    n_state = swbrm_pkg::S_IDLE;
            default:              n_state = swbrm_pkg::S_IDLE;
        endcase
    end

    // handshake and RAM controls
    always_comb begin
        busy      = (r_state != swbrm_pkg::S_IDLE);
        o_valid   = (r_state == swbrm_pkg::S_DONE);
        ram_we    = (r_state == swbrm_pkg::S_ADD_WR);
        ram_raddr = (r_state == swbrm_pkg::S_ADD_RD) ? r_cur : r_addr;
        ram_wdata = bucket_rd + r_bytes;
    end

    assign o_rate_value = r_result;

    // datapath next values
    always_comb begin
        n_op     = r_op;
        n_timer  = r_timer;
        n_cur    = r_cur;
        n_addr   = r_addr;
        n_k      = r_k;
        n_valid  = r_valid;
        n_vq     = r_vq;
        n_pend   = r_pend;
        n_bytes  = r_bytes;
        n_acc    = r_acc;
        n_result = r_result;
        n_prod   = r_prod;
        case (r_state)
            swbrm_pkg::S_IDLE: begin
                // take the request and bring the timer up to date
                if (start) begin
                    n_op     = swbrm_pkg::t_op'(i_opcode);
                    n_bytes  = i_byte_count;
                    n_timer  = timer_sat;
                    n_k      = '0;
                    n_acc    = '0;
                    n_pend   = 1'b0;
                    n_result = '0;
                    n_addr   = (swbrm_pkg::t_op'(i_opcode) == swbrm_pkg::OP_RECENT) ? r_cur : '0;
                end
            end
            swbrm_pkg::S_STEP: begin
                // advance one bucket and drop its contents, or restart the timer
                if (step_go) begin
                    n_cur          = cur_inc;
                    n_valid[cur_inc] = 1'b0;
                    n_timer        = r_timer - TW'(BUCKET_MS);
                    n_k            = r_k + 1'b1;
                end else begin
                    n_timer = '0;
                    n_k     = '0;
                end
            end
            swbrm_pkg::S_ADD_RD: begin
                n_vq = r_valid[r_cur];
            end
            swbrm_pkg::S_ADD_WR: begin
                n_valid[r_cur] = 1'b1;
            end
            swbrm_pkg::S_SUM: begin
                // issue one bucket read and fold in the previous one
                if (r_pend) begin
                    n_acc = r_acc + bucket_rd;
                end
                n_vq   = r_valid[r_addr];
                n_pend = 1'b1;
                n_k    = r_k + 1'b1;
                n_addr = (r_op == swbrm_pkg::OP_AVG) ? addr_inc : addr_dec;
            end
            swbrm_pkg::S_SUM_END: begin
                n_acc    = r_acc + bucket_rd;
                n_result = r_acc + bucket_rd;
            end
            swbrm_pkg::S_MUL: begin
                n_prod = {{BW{1'b0}}, r_acc} * {{BW{1'b0}}, swbrm_pkg::AVG_RECIP};
            end
            swbrm_pkg::S_QUOT: begin
                n_result = BW'(r_prod >> swbrm_pkg::AVG_SHIFT);
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swbrm_pkg::S_IDLE;
            r_timer <= '0;
            r_cur   <= '0;
            r_valid <= '0;
            r_k     <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_timer <= n_timer;
            r_cur   <= n_cur;
            r_valid <= n_valid;
            r_k     <= n_k;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_vq     <= n_vq;
        r_bytes  <= n_bytes;
        r_acc    <= n_acc;
        r_result <= n_result;
        r_prod   <= n_prod;
    end

endmodule

// ----- tb/sv/sliding_window_byte_rate_meter_checker.sv -----
// Checker for the byte-rate meter: predicts each rate and compares it with the strobed result.
`timescale 1ns / 1ps

module sliding_window_byte_rate_meter_checker
    import swbrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [TIME_W-1:0] i_elapsed_ms,
    input  logic [BYTE_W-1:0] i_byte_count,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_rate_value,
    input  logic              i_drain,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    localparam int unsigned AVG_DIVISOR = 5;

    typedef struct {
        int unsigned       seq;
        t_op               op;
        logic [BYTE_W-1:0] rate;
    } t_rate_expect;

    // shadow copy of the meter state
    logic [BYTE_W-1:0] ring_bytes [BUCKETS];
    int unsigned       newest;
    logic [TIME_W-1:0] timer_ms;

    t_rate_expect      expected_rates [$];
    int unsigned       req_seq;
    int                fail_total;
    int                checked_total;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_total++;
    endtask

    // step the ring forward once more than one bucket period has gone by
    function automatic void roll_ring();
        int unsigned steps;
        if (timer_ms <= BUCKET_MS) return;
        steps = timer_ms / BUCKET_MS;
        if (steps > BUCKETS) steps = BUCKETS;
        repeat (steps) begin
            newest             = (newest + 1) % BUCKETS;
            ring_bytes[newest] = '0;
        end
        timer_ms = '0;
    endfunction

    // apply one request to the shadow state and return the rate it should produce
    function automatic logic [BYTE_W-1:0] predict_rate(input t_op op,
                                                       input logic [TIME_W-1:0] dt,
                                                       input logic [BYTE_W-1:0] nbytes);
        logic [TIME_W:0]   total;
        logic [BYTE_W-1:0] acc;
        int unsigned       idx;
        total    = {1'b0, timer_ms} + {1'b0, dt};
        timer_ms = total[TIME_W] ? '1 : total[TIME_W-1:0];
        acc      = '0;
        case (op)
            OP_ADD: begin
                roll_ring();
                ring_bytes[newest] = ring_bytes[newest] + nbytes;
            end
            OP_AVG: begin
                roll_ring();
                for (int k = 0; k < BUCKETS; k++) acc = acc + ring_bytes[k];
                acc = acc / AVG_DIVISOR;
            end
            OP_RECENT: begin
                // stale window reads as zero; walk back from the newest bucket
                if (timer_ms <= RECENT_LIMIT_MS) begin
                    idx = newest;
                    for (int k = 0; k < RECENT_BUCKETS; k++) begin
                        acc = acc + ring_bytes[idx];
                        idx = (idx == 0) ? BUCKETS - 1 : idx - 1;
                    end
                end
            end
            default: ;
        endcase
        return acc;
    endfunction

    // retire results first, then queue the prediction for a newly taken request
    always @(posedge i_clk) begin
        t_rate_expect head;
        t_rate_expect fresh;
        if (!i_rst_n) begin
            for (int k = 0; k < BUCKETS; k++) ring_bytes[k] = '0;
            newest        = 0;
            timer_ms      = '0;
            req_seq       = 0;
            fail_total    = 0;
            checked_total = 0;
            expected_rates.delete();
        end else begin
            if (i_valid) begin
                if (expected_rates.size() == 0) begin
                    report_mismatch($sformatf("result 0x%08h with no request outstanding",
                                              i_rate_value));
                end else begin
                    head = expected_rates.pop_front();
                    checked_total++;
                    if (i_rate_value !== head.rate)
                        report_mismatch($sformatf("request %0d (%s): rate 0x%08h, want 0x%08h",
                                                  head.seq, head.op.name(), i_rate_value,
                                                  head.rate));
                end
            end
            if (i_start && !i_busy) begin
                fresh.seq  = req_seq;
                fresh.op   = t_op'(i_opcode);
                fresh.rate = predict_rate(t_op'(i_opcode), i_elapsed_ms, i_byte_count);
                expected_rates.push_back(fresh);
                req_seq++;
            end
            if (i_drain) begin
                while (expected_rates.size() != 0) begin
                    head = expected_rates.pop_front();
                    report_mismatch($sformatf("request %0d (%s): result never arrived",
                                              head.seq, head.op.name()));
                end
            end
        end
        o_pending <= expected_rates.size();
    end

endmodule

// ----- tb/sv/tb_sliding_window_byte_rate_meter_top.sv -----
// Testbench top for the byte-rate meter: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_sliding_window_byte_rate_meter_top;
    import swbrm_pkg::*;

    localparam int          RANDOM_PER_PHASE = 175;
    localparam int unsigned MAX_GAP          = 40;
    localparam int unsigned DRAIN_LIMIT      = 5000;
    localparam int unsigned TAIL_CYCLES      = 60;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_opcode;
    logic [TIME_W-1:0] i_elapsed_ms;
    logic [BYTE_W-1:0] i_byte_count;
    logic              o_valid;
    logic [BYTE_W-1:0] o_rate_value;
    logic              drain;

    int                fail_count;
    int                pending;
    int                checked;
    int unsigned       idle_pct;
    int                ops_sent [4];

    always #5 i_clk = ~i_clk;

    sliding_window_byte_rate_meter_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_elapsed_ms (i_elapsed_ms),
        .i_byte_count (i_byte_count),
        .o_valid      (o_valid),
        .o_rate_value (o_rate_value)
    );

    sliding_window_byte_rate_meter_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_opcode     (i_opcode),
        .i_elapsed_ms (i_elapsed_ms),
        .i_byte_count (i_byte_count),
        .i_valid      (o_valid),
        .i_rate_value (o_rate_value),
        .i_drain      (drain),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // hold start low for a random gap, then present the request until it is taken
    task automatic issue_request(input t_op op, input logic [TIME_W-1:0] dt,
                                 input logic [BYTE_W-1:0] nbytes);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_elapsed_ms <= dt;
        i_byte_count <= nbytes;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ops_sent[op]++;
    endtask

    // drop start and wait for every outstanding result
    task automatic wait_all_results();
        @(negedge i_clk);
        start <= 1'b0;
        for (int unsigned c = 0; c < DRAIN_LIMIT && pending != 0; c++) @(posedge i_clk);
    endtask

    initial begin
        int unsigned       pick;
        t_op               op;
        logic [TIME_W-1:0] dt;
        logic [BYTE_W-1:0] nbytes;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_opcode     = OP_ADD;
        i_elapsed_ms = '0;
        i_byte_count = '0;
        drain        = 1'b0;
        idle_pct     = 0;
        for (int k = 0; k < 4; k++) ops_sent[k] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // queries on an empty ring, then wrapping bucket sums
        issue_request(OP_AVG,    16'd0, 32'h0);
        issue_request(OP_RECENT, 16'd0, 32'h0);
        issue_request(OP_ADD,    16'd0, 32'hFFFF_FFFF);
        issue_request(OP_ADD,    16'd0, 32'hFFFF_FFFF);
        issue_request(OP_RECENT, 16'd0, 32'h0);
        // timer exactly one period holds the ring, one more ms advances it
        issue_request(OP_ADD,    16'd250, 32'd100);
        issue_request(OP_ADD,    16'd1,   32'd7);
        issue_request(OP_AVG,    16'd0,   32'h0);
        // leftover time below a period is dropped
        issue_request(OP_ADD,    16'd499, 32'd1);
        issue_request(OP_RECENT, 16'd249, 32'h0);
        issue_request(OP_ADD,    16'd1000, 32'hFFFF_0000);
        issue_request(OP_RECENT, 16'd0,   32'h0);
        // recent right at the stale limit, then just past it
        issue_request(OP_RECENT, 16'd5000, 32'h0);
        issue_request(OP_RECENT, 16'd1,    32'h0);
        // unused opcode drives the timer into saturation
        issue_request(OP_NONE,   16'hFFFF, 32'hFFFF_FFFF);
        issue_request(OP_NONE,   16'hFFFF, 32'h0);
        issue_request(OP_RECENT, 16'd0,    32'h0);
        issue_request(OP_AVG,    16'd0,    32'h0);
        // full-ring advances and a wrapped average
        issue_request(OP_ADD,    16'd5249, 32'hAAAA_AAAA);
        issue_request(OP_ADD,    16'd5250, 32'h5555_5555);
        issue_request(OP_ADD,    16'd300,  32'hFFFF_FFFF);
        issue_request(OP_AVG,    16'd0,    32'h0);
        issue_request(OP_ADD,    16'd0,    32'h0);
        issue_request(OP_NONE,   16'd0,    32'h0);

        // random traffic in four phases under three idling profiles
        for (int phase = 0; phase < 4; phase++) begin
            wait_all_results();
            case (phase)
                1:       idle_pct = 80;
                3:       idle_pct = 36;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50)      op = OP_ADD;
                else if (pick < 70) op = OP_AVG;
                else if (pick < 95) op = OP_RECENT;
                else                op = OP_NONE;
                // mostly packet-rate gaps, sometimes long silences
                pick = $urandom_range(0, 99);
                if (pick < 60)      dt = TIME_W'($urandom_range(0, 300));
                else if (pick < 85) dt = TIME_W'($urandom_range(0, 1500));
                else if (pick < 95) dt = TIME_W'($urandom_range(0, 6000));
                else                dt = TIME_W'($urandom_range(0, 65535));
                pick = $urandom_range(0, 99);
                if (pick < 50)      nbytes = $urandom_range(0, 2000);
                else if (pick < 80) nbytes = $urandom;
                else                nbytes = 32'hFFFF_FF00 | $urandom_range(0, 255);
                if ($urandom_range(0, 99) < 2) wait_all_results();
                issue_request(op, dt, nbytes);
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        drain <= 1'b1;
        @(negedge i_clk);
        drain <= 1'b0;

        $display("Covered %0d add, %0d average, %0d recent and %0d unused requests,",
                 ops_sent[OP_ADD], ops_sent[OP_AVG], ops_sent[OP_RECENT], ops_sent[OP_NONE]);
        $display("with sender gaps of 0, 80 and 36 percent; %0d rates compared.", checked);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // bound the run well past the slowest legal schedule
    initial begin
        #5_000_000;
        $display("Timed out waiting for the meter");
        $display("== FAIL ==");
        $finish;
    end

endmodule
